@@ design/fbc_pkg.sv @@
// Shared types and constants for the frustum box cull block.
// Holds fixed-point widths, register indexes and plane coefficient types.
// No dependencies.
package fbc_pkg;

    localparam int NUM_REGS = 8;
    localparam int REG_W    = 64;
    localparam int ADDR_W   = 6;
    localparam int ENTRY_W  = 32;
    localparam int COORD_W  = 32;
    localparam int COEF_W   = 33;
    localparam int PROD_W   = COEF_W + COORD_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int FRAC_W   = 16;
    localparam int NUM_AXES = 3;
    localparam int NUM_PLANES = 6;

    localparam logic [2:0] REG_R0_C01 = 3'd0;
    localparam logic [2:0] REG_R0_C23 = 3'd1;
    localparam logic [2:0] REG_R1_C01 = 3'd2;
    localparam logic [2:0] REG_R1_C23 = 3'd3;
    localparam logic [2:0] REG_R2_C01 = 3'd4;
    localparam logic [2:0] REG_R2_C23 = 3'd5;
    localparam logic [2:0] REG_R3_C01 = 3'd6;
    localparam logic [2:0] REG_R3_C23 = 3'd7;

    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    // Coefficients a, b, c in entries 0..2 and the offset d in entry 3.
    typedef coef_t plane_t [4];

    typedef struct packed {
        logic load_prod;
    } ctrl_t;

    function automatic coef_t sext_entry(input logic [ENTRY_W-1:0] e);
        return {e[ENTRY_W-1], e};
    endfunction

endpackage

@@ design/fbc_plane.sv @@
// One clipping plane of the frustum test: per-axis corner choice, product
// register and the signed distance check. Depends on fbc_pkg.
module fbc_plane (
    input  logic             clk,
    input  fbc_pkg::ctrl_t   ctrl,
    input  fbc_pkg::plane_t  coef,
    input  fbc_pkg::coord_t  box_lo [3],
    input  fbc_pkg::coord_t  box_hi [3],
    output logic             in_plane
);
    import fbc_pkg::*;

    prod_t  prod_reg [NUM_AXES];
    prod_t  prod_next [NUM_AXES];
    coord_t sel [NUM_AXES];
    acc_t   offset;
    acc_t   distance;

    // The corner furthest along the normal: maximum for a non-negative
    // coefficient, minimum otherwise.
    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            sel[k]       = coef[k][COEF_W-1] ? box_lo[k] : box_hi[k];
            prod_next[k] = coef[k] * sel[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_prod)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
        end
    end

    always_comb
    begin
        offset   = {{(ACC_W - COEF_W - FRAC_W){coef[3][COEF_W-1]}}, coef[3], {FRAC_W{1'b0}}};
        distance = offset
                 + {{(ACC_W - PROD_W){prod_reg[0][PROD_W-1]}}, prod_reg[0]}
                 + {{(ACC_W - PROD_W){prod_reg[1][PROD_W-1]}}, prod_reg[1]}
                 + {{(ACC_W - PROD_W){prod_reg[2][PROD_W-1]}}, prod_reg[2]};
        in_plane = ~distance[ACC_W-1];
    end

endmodule

@@ design/frustum_box_cull.sv @@
// Top level of the frustum box cull block: configuration registers, plane
// formation, the beat pipeline and the six plane units.
// Depends on fbc_pkg and fbc_plane.
//
// Use: the view-projection matrix is written over the APB port, two Q15.16
// entries per 64-bit register at byte address 8*i. Each beat on the s_axis
// channel carries one axis-aligned box; each box gives one beat on m_axis
// whose bit 0 is 1 when the box touches or lies inside all six planes.
// From input acceptance to the result showing on m_axis, a box passes an
// input register, a product register and the result register.
// Throughput is one box per cycle; the three pipeline registers each hold
// a beat, so a stall on m_axis fills them in turn before s_axis_tready
// falls, and bubbles collapse as soon as the receiver takes a result.
// Reset clears all matrix entries to zero and empties the pipeline.
// The matrix must only be written while no box is in flight.
module frustum_box_cull (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z (32 bits each, lowest first)
    input  logic [191:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // visible in bit 0, zeros above
    output logic [7:0]    m_axis_tdata
);
    import fbc_pkg::*;

    logic [REG_W-1:0] cfg_reg [NUM_REGS];
    logic [2:0]       cfg_idx;

    coef_t  row [4][4];
    plane_t plane_next [NUM_PLANES];
    plane_t plane_reg  [NUM_PLANES];

    coord_t box_lo_reg [NUM_AXES];
    coord_t box_hi_reg [NUM_AXES];

    logic v0_reg;
    logic v1_reg;
    logic v2_reg;
    logic ready0;
    logic ready1;
    logic ready2;
    logic visible_reg;
    logic visible_next;
    logic [NUM_PLANES-1:0] in_plane;
    ctrl_t ctrl;

    assign cfg_idx = paddr[5:3];
    assign pready  = 1'b1;
    assign prdata  = cfg_reg[cfg_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (psel && penable && pwrite && pready)
        begin
            cfg_reg[cfg_idx] <= pwdata;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            row[r][0] = sext_entry(cfg_reg[2*r][ENTRY_W-1:0]);
            row[r][1] = sext_entry(cfg_reg[2*r][REG_W-1:ENTRY_W]);
            row[r][2] = sext_entry(cfg_reg[2*r+1][ENTRY_W-1:0]);
            row[r][3] = sext_entry(cfg_reg[2*r+1][REG_W-1:ENTRY_W]);
        end
        for (int c = 0; c < 4; c++)
        begin
            plane_next[0][c] = row[3][c] + row[0][c];
            plane_next[1][c] = row[3][c] - row[0][c];
            plane_next[2][c] = row[3][c] + row[1][c];
            plane_next[3][c] = row[3][c] - row[1][c];
            plane_next[4][c] = row[2][c];
            plane_next[5][c] = row[3][c] - row[2][c];
        end
    end

    // The user must change the matrix only while the pipeline is empty; the
    // block does not enforce it, so planes settle before any box arrives.
    always_ff @(posedge clk)
    begin
        plane_reg <= plane_next;
    end

    assign ready2        = ~v2_reg | m_axis_tready;
    assign ready1        = ~v1_reg | ready2;
    assign ready0        = ~v0_reg | ready1;
    assign s_axis_tready = ready0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ready0)
            begin
                v0_reg <= s_axis_tvalid;
            end
            if (ready1)
            begin
                v1_reg <= v0_reg;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready0 && s_axis_tvalid)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                box_lo_reg[k] <= s_axis_tdata[k*COORD_W +: COORD_W];
                box_hi_reg[k] <= s_axis_tdata[(k+NUM_AXES)*COORD_W +: COORD_W];
            end
        end
    end

    assign ctrl.load_prod = ready1 & v0_reg;

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_plane
        fbc_plane u_plane (
            .clk      (clk),
            .ctrl     (ctrl),
            .coef     (plane_reg[p]),
            .box_lo   (box_lo_reg),
            .box_hi   (box_hi_reg),
            .in_plane (in_plane[p])
        );
    end

    assign visible_next = &in_plane;

    always_ff @(posedge clk)
    begin
        if (ready2 && v1_reg)
        begin
            visible_reg <= visible_next;
        end
    end

    assign m_axis_tvalid = v2_reg;
    assign m_axis_tdata  = {7'b0, visible_reg};

endmodule

@@ sim/frustum_box_cull_test.sv @@
`timescale 1ns / 1ps
// Testbench for frustum_box_cull: writes view-projection matrices over APB, streams boxes
// and checks every visibility beat against a plane-by-plane predictor kept in this file.
// Depends on fbc_pkg and the frustum_box_cull RTL.
module frustum_box_cull_test;
    import fbc_pkg::*;

    localparam logic [31:0] ONE       = 32'h0001_0000;
    localparam logic [31:0] HALF      = 32'h0000_8000;
    localparam logic [31:0] COORD_MIN = 32'h8000_0000;
    localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam int RANDOM_BOXES = 1400;
    localparam int PHASE_BOXES  = 100;

    typedef struct packed {
        coord_t max_z;
        coord_t max_y;
        coord_t max_x;
        coord_t min_z;
        coord_t min_y;
        coord_t min_x;
    } box_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_PATTERN,
        READY_SPARSE
    } ready_mode_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [5:0]    paddr = '0;
    logic [63:0]   pwdata = '0;
    logic [63:0]   prdata;
    logic          pready;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    // min_x, min_y, min_z, max_x, max_y, max_z (32 bits each, lowest first)
    logic [191:0]  s_axis_tdata = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    // visible in bit 0, zeros above
    logic [7:0]    m_axis_tdata;

    logic [63:0]   matrix_regs [NUM_REGS];
    logic [31:0]   mat [16];
    logic          visible_due [$];
    logic          due_visible;
    int            mismatch_count = 0;
    int            result_index = 0;
    bit            sender_idles = 1'b0;
    int            burst_left = 1;

    ready_mode_t   ready_mode = READY_ALWAYS;
    logic [15:0]   ready_pattern = 16'hFFFF;
    int            ready_cycle = 0;

    frustum_box_cull DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 clk = ~clk;

    function automatic logic predict_visible(input box_t b);
        coef_t              row [4][4];
        coef_t              pl [6][4];
        coord_t             lo [3];
        coord_t             hi [3];
        logic [31:0]        w;
        logic signed [79:0] distance;
        logic signed [79:0] coef;
        logic signed [79:0] corner;
        logic               vis;
        lo[0] = b.min_x;
        lo[1] = b.min_y;
        lo[2] = b.min_z;
        hi[0] = b.max_x;
        hi[1] = b.max_y;
        hi[2] = b.max_z;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                w = matrix_regs[2*r + c/2][32*(c%2) +: 32];
                row[r][c] = {w[31], w};
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            pl[0][c] = row[3][c] + row[0][c];
            pl[1][c] = row[3][c] - row[0][c];
            pl[2][c] = row[3][c] + row[1][c];
            pl[3][c] = row[3][c] - row[1][c];
            pl[4][c] = row[2][c];
            pl[5][c] = row[3][c] - row[2][c];
        end
        vis = 1'b1;
        for (int p = 0; p < 6; p++)
        begin
            distance = pl[p][3];
            distance = distance <<< FRAC_W;
            for (int k = 0; k < 3; k++)
            begin
                coef = pl[p][k];
                corner = (pl[p][k] >= 0) ? hi[k] : lo[k];
                distance = distance + coef * corner;
            end
            if (distance < 0)
                vis = 1'b0;
        end
        return vis;
    endfunction

    function automatic box_t box_of(input logic [31:0] x0, input logic [31:0] y0,
                                    input logic [31:0] z0, input logic [31:0] x1,
                                    input logic [31:0] y1, input logic [31:0] z1);
        box_t b;
        b.min_x = x0;
        b.min_y = y0;
        b.min_z = z0;
        b.max_x = x1;
        b.max_y = y1;
        b.max_z = z1;
        return b;
    endfunction

    function automatic box_t random_box(input logic [31:0] reach);
        logic [31:0] mid;
        logic [31:0] half;
        logic [31:0] swap;
        logic [31:0] lo [3];
        logic [31:0] hi [3];
        int          kind;
        kind = $urandom_range(0, 19);
        for (int k = 0; k < 3; k++)
        begin
            mid = $urandom_range(0, 2 * reach) - reach;
            half = $urandom_range(0, reach / 2);
            lo[k] = mid - half;
            hi[k] = mid + half;
            if (kind < 3)
            begin
                lo[k] = $urandom;
                hi[k] = $urandom;
            end
            else if (kind < 5)
            begin
                swap = lo[k];
                lo[k] = hi[k];
                hi[k] = swap;
            end
            else if (kind == 5)
            begin
                lo[k] = ($urandom_range(0, 1) == 1) ? COORD_MIN : lo[k];
                hi[k] = ($urandom_range(0, 1) == 1) ? COORD_MAX : hi[k];
            end
        end
        return box_of(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    task automatic send_box(input box_t b);
        logic taken;
        s_axis_tdata <= b;
        s_axis_tvalid <= 1'b1;
        do
        begin
            @(negedge clk);
            taken = (s_axis_tready === 1'b1);
            @(posedge clk);
        end
        while (!taken);
        if (sender_idles)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
        logic done;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            done = (pready === 1'b1);
            @(posedge clk);
        end
        while (!done);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        matrix_regs[index] = value;
        @(posedge clk);
    endtask

    task automatic load_matrix();
        write_reg(REG_R0_C01, {mat[1], mat[0]});
        write_reg(REG_R0_C23, {mat[3], mat[2]});
        write_reg(REG_R1_C01, {mat[5], mat[4]});
        write_reg(REG_R1_C23, {mat[7], mat[6]});
        write_reg(REG_R2_C01, {mat[9], mat[8]});
        write_reg(REG_R2_C23, {mat[11], mat[10]});
        write_reg(REG_R3_C01, {mat[13], mat[12]});
        write_reg(REG_R3_C23, {mat[15], mat[14]});
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (visible_due.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic check_reset_matrix();
        sender_idles = 1'b0;
        send_box(box_of(0, 0, 0, 0, 0, 0));
        send_box(box_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(box_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
        drain();
    endtask

    task automatic check_identity_frustum();
        foreach (mat[i])
            mat[i] = '0;
        mat[0] = ONE;
        mat[5] = ONE;
        mat[10] = ONE;
        mat[15] = ONE;
        load_matrix();
        sender_idles = 1'b1;
        burst_left = 2;
        send_box(box_of(-HALF, -HALF, 0, HALF, HALF, HALF));
        send_box(box_of(2*ONE, 0, 0, 3*ONE, HALF, HALF));
        send_box(box_of(-3*ONE, 0, 0, -2*ONE, HALF, HALF));
        send_box(box_of(0, 2*ONE, 0, HALF, 3*ONE, HALF));
        send_box(box_of(0, -3*ONE, 0, HALF, -2*ONE, HALF));
        send_box(box_of(0, 0, -2*ONE, HALF, HALF, -ONE));
        send_box(box_of(0, 0, 2*ONE, HALF, HALF, 3*ONE));
        send_box(box_of(ONE, 0, 0, 2*ONE, HALF, HALF));
        send_box(box_of(0, 0, -ONE, HALF, HALF, 0));
        send_box(box_of(0, 0, ONE, HALF, HALF, 2*ONE));
        send_box(box_of(-3*ONE, -3*ONE, -3*ONE, 3*ONE, 3*ONE, 3*ONE));
        send_box(box_of(ONE, ONE, ONE, -ONE, -ONE, -ONE));
        send_box(box_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        drain();
    endtask

    task automatic check_extreme_matrix();
        for (int m = 0; m < 4; m++)
        begin
            for (int i = 0; i < 16; i++)
            begin
                if (i < 12)
                    mat[i] = (m == 0 || m == 3) ? COORD_MAX : COORD_MIN;
                else
                    mat[i] = (m == 0 || m == 2) ? COORD_MAX : COORD_MIN;
            end
            load_matrix();
            send_box(box_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
            send_box(box_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
            drain();
        end
    endtask

    task automatic check_random_boxes();
        int          sent;
        int          style;
        logic [31:0] reach;
        sent = 0;
        while (sent < RANDOM_BOXES)
        begin
            drain();
            style = $urandom_range(0, 3);
            for (int i = 0; i < 16; i++)
            begin
                case (style)
                    0:       mat[i] = $urandom;
                    1:       mat[i] = $urandom_range(0, 32'h80000) - 32'h40000;
                    default: mat[i] = $urandom_range(0, 32'h8000) - 32'h4000;
                endcase
            end
            if (style >= 2)
            begin
                mat[0] += $urandom_range(ONE / 4, 4 * ONE);
                mat[5] += $urandom_range(ONE / 4, 4 * ONE);
                mat[10] += $urandom_range(ONE / 4, 2 * ONE);
                mat[15] += $urandom_range(ONE / 2, 2 * ONE);
            end
            // A perspective-style fourth row makes w follow z.
            if (style == 3)
                mat[14] += ONE;
            load_matrix();
            case ($urandom_range(0, 2))
                0:       reach = 2 * ONE;
                1:       reach = 8 * ONE;
                default: reach = 64 * ONE;
            endcase
            sender_idles = ($urandom_range(0, 3) != 0);
            burst_left = $urandom_range(1, 12);
            for (int i = 0; i < PHASE_BOXES; i++)
                send_box(random_box(reach));
            sent += PHASE_BOXES;
        end
    endtask

    always @(posedge clk)
    begin
        if (ready_cycle % 173 == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_pattern = 16'($urandom) | 16'h0001;
        end
        ready_cycle++;
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
        case (ready_mode)
            READY_ALWAYS:  m_axis_tready <= 1'b1;
            READY_COIN:    m_axis_tready <= ($urandom_range(0, 1) == 1);
            READY_PATTERN: m_axis_tready <= ready_pattern[0];
            default:       m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // Both channels are stable between the falling edge and the next rising edge,
    // so a beat seen here is the one taken at that rising edge.
    always @(negedge clk)
    begin
        if (rst_n && s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)
            visible_due.push_back(predict_visible(box_t'(s_axis_tdata)));
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            if (visible_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("beat %0d: visible=%0b arrived with nothing outstanding",
                             result_index, m_axis_tdata[0]);
            end
            else
            begin
                due_visible = visible_due.pop_front();
                if (m_axis_tdata[0] !== due_visible)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("beat %0d: visible expected %0b, got %0b",
                                 result_index, due_visible, m_axis_tdata[0]);
                end
            end
            result_index++;
        end
    end

    initial
    begin
        foreach (matrix_regs[i])
            matrix_regs[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_reset_matrix();
        check_identity_frustum();
        check_extreme_matrix();
        check_random_boxes();
        drain();
        if (visible_due.size() != 0)
        begin
            mismatch_count++;
            $display("%0d visibility beats never arrived", visible_due.size());
        end
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
design/fbc_pkg.sv
design/fbc_plane.sv
design/frustum_box_cull.sv
sim/frustum_box_cull_test.sv
